### sv/assert_macros.svh
// assertion macros shared by the rc4 core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rc4_pkg.sv
// types and constants shared by the rc4 core
package rc4_pkg;

    localparam int STATE_SIZE = 256;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_LEN_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

    localparam logic MODE_DATA    = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;
    localparam logic [BYTE_W-1:0]    IDX_LAST      = 8'hFF;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic  we;
        byte_t waddr;
        byte_t wdata;
        byte_t raddr;
    } ram_req_t;

    typedef struct packed {
        byte_t data_out;
        logic  keyed;
        logic  last;
    } result_t;

    typedef struct packed {
        logic idle;
        logic res_load;
    } seq_status_t;

endpackage

### sv/rc4_if.sv
// stream and configuration channel interfaces of the rc4 core
interface rc4_in_if import rc4_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  mode;
    byte_t data_byte;
    logic  end_of_message;

    modport source (output valid, mode, data_byte, end_of_message, input ready);
    modport sink   (input valid, mode, data_byte, end_of_message, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t data_out;
    logic  keyed;
    logic  last;

    modport source (output valid, data_out, keyed, last, input ready);
    modport sink   (input valid, data_out, keyed, last, output ready);
endinterface

interface rc4_cfg_if import rc4_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/rc4_keys.sv
// key configuration registers with byte select and length clamp
module rc4_keys import rc4_pkg::*; #(
    parameter int KEY_BYTES = 16,
    parameter int KIDX_W    = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [KIDX_W-1:0]     kidx,
    output byte_t                 key_byte,
    output logic [KEY_LEN_W-1:0]  key_len
);

    byte_t                key_reg [KEY_BYTES];
    logic [KEY_LEN_W-1:0] key_length_reg;

    for (genvar k = 0; k < KEY_BYTES; k++) begin : g_key
        localparam int                   LANE = k % 8;
        localparam logic [CFG_IDX_W-1:0] SEL  = (k < 8) ? CFG_KEY_LOW : CFG_KEY_HIGH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                key_reg[k] <= '0;
            end
            else if (cfg_we && cfg_index == SEL)
            begin
                key_reg[k] <= cfg_data[BYTE_W*LANE +: BYTE_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LEN_RESET;
        end
        else if (cfg_we && cfg_index == CFG_KEY_LENGTH)
        begin
            key_length_reg <= cfg_data[KEY_LEN_W-1:0];
        end
    end

    // zero means one byte, anything past the key store means all of it
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            key_len = 5'd1;
        end
        else if (key_length_reg > KEY_LEN_W'(KEY_BYTES))
        begin
            key_len = KEY_LEN_W'(KEY_BYTES);
        end
        else
        begin
            key_len = key_length_reg;
        end
    end

    assign key_byte = key_reg[kidx];

endmodule

### sv/rc4_sbox.sv
// 256 x 8 permutation memory, one write and one registered read per cycle
module rc4_sbox import rc4_pkg::*; (
    input  logic     clk,
    input  ram_req_t req,
    output byte_t    rdata
);

    byte_t mem [STATE_SIZE];
    byte_t rdata_reg;

    // read returns the contents before a same-cycle write
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/rc4_seq.sv
// sequencer for key schedule and keystream steps around one shared byte adder
module rc4_seq import rc4_pkg::*; #(
    parameter int KIDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 in_mode,
    input  byte_t                in_data,
    input  logic                 in_eom,
    input  byte_t                key_byte,
    input  logic [KEY_LEN_W-1:0] key_len,
    input  byte_t                rdata,
    input  logic                 out_free,
    output logic [KIDX_W-1:0]    kidx,
    output ram_req_t             ram_req,
    output result_t              result,
    output seq_status_t          status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_KS_RD_I,
        S_KS_RD_J,
        S_KS_WR_I,
        S_KS_WR_J,
        S_GEN_RD_J,
        S_GEN_WR_I,
        S_GEN_WR_J,
        S_GEN_XOR,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    byte_t              n_reg, n_next;
    logic [KIDX_W-1:0]  kidx_reg, kidx_next;
    byte_t              i_reg, i_next;
    byte_t              j_reg, j_next;
    byte_t              si_reg, si_next;
    byte_t              t_reg, t_next;
    logic               hit_reg, hit_next;
    logic               keyed_reg, keyed_next;
    byte_t              data_reg, data_next;
    logic               last_reg, last_next;

    byte_t add_a, add_b, add_c, sum;
    byte_t ks;
    logic  res_load;

    // the one adder that every sum goes through
    assign sum = add_a + add_b + add_c;

    // forward the swapped value when the output index hit the slot written last
    assign ks = hit_reg ? si_reg : rdata;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        kidx_next  = kidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        si_next    = si_reg;
        t_next     = t_reg;
        hit_next   = hit_reg;
        keyed_next = keyed_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        add_a      = '0;
        add_b      = '0;
        add_c      = '0;
        ram_req    = '0;
        res_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                add_a = i_reg;
                add_c = 8'd1;
                if (start)
                begin
                    data_next = in_data;
                    last_next = in_eom;
                    if (in_mode == MODE_RESTART)
                    begin
                        n_next     = '0;
                        state_next = S_FILL;
                    end
                    else if (keyed_reg)
                    begin
                        i_next        = sum;
                        ram_req.raddr = sum;
                        state_next    = S_GEN_RD_J;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                add_a         = n_reg;
                add_c         = 8'd1;
                ram_req.we    = 1'b1;
                ram_req.waddr = n_reg;
                ram_req.wdata = n_reg;
                n_next        = sum;
                if (n_reg == IDX_LAST)
                begin
                    kidx_next  = '0;
                    j_next     = '0;
                    state_next = S_KS_RD_I;
                end
            end
            S_KS_RD_I:
            begin
                ram_req.raddr = n_reg;
                state_next    = S_KS_RD_J;
            end
            S_KS_RD_J:
            begin
                add_a         = j_reg;
                add_b         = rdata;
                add_c         = key_byte;
                j_next        = sum;
                si_next       = rdata;
                ram_req.raddr = sum;
                state_next    = S_KS_WR_I;
            end
            S_KS_WR_I:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = n_reg;
                ram_req.wdata = rdata;
                state_next    = S_KS_WR_J;
            end
            S_KS_WR_J:
            begin
                add_a         = n_reg;
                add_c         = 8'd1;
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = si_reg;
                n_next        = sum;
                if (KEY_LEN_W'(kidx_reg) == key_len - 5'd1)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + KIDX_W'(1);
                end
                if (n_reg == IDX_LAST)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_KS_RD_I;
                end
            end
            S_GEN_RD_J:
            begin
                add_a         = j_reg;
                add_b         = rdata;
                j_next        = sum;
                si_next       = rdata;
                ram_req.raddr = sum;
                state_next    = S_GEN_WR_I;
            end
            S_GEN_WR_I:
            begin
                add_a         = si_reg;
                add_b         = rdata;
                t_next        = sum;
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = rdata;
                state_next    = S_GEN_WR_J;
            end
            S_GEN_WR_J:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = si_reg;
                ram_req.raddr = t_reg;
                hit_next      = (t_reg == j_reg);
                state_next    = S_GEN_XOR;
            end
            S_GEN_XOR:
            begin
                data_next = data_reg ^ ks;
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            kidx_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            keyed_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            kidx_reg  <= kidx_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            keyed_reg <= keyed_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        t_reg    <= t_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign kidx            = kidx_reg;
    assign result.data_out = (state_reg == S_GEN_XOR) ? (data_reg ^ ks) : data_reg;
    assign result.keyed    = keyed_reg;
    assign result.last     = last_reg;
    assign status.idle     = (state_reg == S_IDLE);
    assign status.res_load = res_load;

endmodule

### sv/rc4_stream_cipher_core.sv
// rc4 stream cipher core top level
// keyed data beat: read j, write i, write j and xor states, then the result enters the output register
// unkeyed data beat: the done state loads the byte unchanged; a new beat is accepted only back in idle
// restart gives no result and holds off input while it fills all 256 entries and runs the key schedule
// steps follow the one-read one-write permutation memory and shared adder; a result stall waits in done
// reset clears indices, keyed flag and key bytes, sets key length to 16; permutation is loaded by restart
`include "assert_macros.svh"
module rc4_stream_cipher_core import rc4_pkg::*; #(
    parameter int KEY_BYTES = 16
) (
    input logic     clk,
    input logic     rst_n,
    rc4_in_if.sink  din,
    rc4_out_if.source dout,
    rc4_cfg_if.sink cfg
);

    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic                 cfg_we;
    logic                 start;
    logic                 out_free;
    logic [KIDX_W-1:0]    kidx;
    byte_t                key_byte;
    logic [KEY_LEN_W-1:0] key_len;
    byte_t                rdata;
    ram_req_t             ram_req;
    result_t              result;
    seq_status_t          status;

    logic    out_valid_reg;
    result_t out_reg;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;
    assign din.ready = status.idle;
    assign start     = din.valid && din.ready;
    assign out_free  = !out_valid_reg || dout.ready;

    rc4_keys #(
        .KEY_BYTES (KEY_BYTES),
        .KIDX_W    (KIDX_W)
    ) u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .kidx      (kidx),
        .key_byte  (key_byte),
        .key_len   (key_len)
    );

    rc4_sbox u_sbox (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    rc4_seq #(
        .KIDX_W (KIDX_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_mode  (din.mode),
        .in_data  (din.data_byte),
        .in_eom   (din.end_of_message),
        .key_byte (key_byte),
        .key_len  (key_len),
        .rdata    (rdata),
        .out_free (out_free),
        .kidx     (kidx),
        .ram_req  (ram_req),
        .result   (result),
        .status   (status)
    );

    // output register decouples the result beat from the next input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (status.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.res_load)
        begin
            out_reg <= result;
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.data_out = out_reg.data_out;
    assign dout.keyed    = out_reg.keyed;
    assign dout.last     = out_reg.last;

    `ASSERT_IMPLY(a_load_into_free_slot, clk, rst_n, status.res_load, out_free,
        "result loaded over a pending beat")
    `ASSERT_NEXT(a_restart_no_result, clk, rst_n, start && din.mode == MODE_RESTART,
        !status.res_load, "restart produced a result")
    `ASSERT_IMPLY(a_idle_no_ram_write, clk, rst_n, status.idle, !ram_req.we,
        "permutation written while idle")

endmodule
